// File: design/olc_pkg.sv
// shared constants, command codes and cell control type for the ordered list
package olc_pkg;

   localparam int DEPTH   = 16;
   localparam int VALUE_W = 32;
   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);

   // request and response field widths
   localparam int CMD_W       = 3;
   localparam int ITEM_W      = 32;
   localparam int ENTRY_CNT_W = 5;

   localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_ADVANCE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_RESTART = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

   typedef struct packed {
      logic               append_en;
      logic               remove_en;
      logic [VALUE_W-1:0] key;
      logic [IDX_W-1:0]   pos;
      logic [CNT_W-1:0]   count;
   } olc_ctl_type;

endpackage

// File: design/olc_if.sv
// request and response channel interfaces of the ordered list
interface olc_req_if;
   import olc_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [ITEM_W-1:0] item_value;

   modport source (output valid, input ready, output cmd, output item_value);
   modport sink   (input valid, output ready, input cmd, input item_value);
endinterface

interface olc_rsp_if;
   import olc_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   accepted;
   logic [ENTRY_CNT_W-1:0] entry_count;
   logic                   cursor_valid;
   logic [ITEM_W-1:0]      cursor_value;

   modport source (output valid, input ready, output accepted, output entry_count,
                   output cursor_valid, output cursor_value);
   modport sink   (input valid, output ready, input accepted, input entry_count,
                   input cursor_valid, input cursor_value);
endinterface

// File: design/ordered_list_with_cursor.sv
// ordered list with iteration cursor built from a row of compare-and-shift cells
//
//   channel | dir | handshake     | payload
//   req_    | in  | valid / ready | cmd, item_value
//   rsp_    | out | valid / ready | accepted, entry_count, cursor_valid, cursor_value
//
// each request passes IDLE then RESP: the cell row updates at the accept edge, the
// cursor slot is read out of the row into the response register on the next edge
// a new request is taken while the previous response still waits, as long as it is
// taken in the same cycle; otherwise req.ready stays low until rsp is taken
// synchronous reset empties the list and parks the cursor; slot contents are not cleared
module ordered_list_with_cursor (
   input  logic         clock,
   input  logic         reset,
   olc_req_if.sink      req,
   olc_rsp_if.source    rsp
);
   import olc_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RESP = 1'b1;

   logic                   phase_ff, phase_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [IDX_W-1:0]       cur_ff, cur_in;
   logic                   present_ff, present_in;
   logic                   adv_ff, adv_in;
   logic                   acc_ff, acc_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_acc_ff;
   logic [ENTRY_CNT_W-1:0] rsp_count_ff;
   logic                   rsp_cv_ff;
   logic [ITEM_W-1:0]      rsp_value_ff;

   logic                   accept;
   olc_ctl_type            ctl;
   logic [VALUE_W-1:0]     cell_value [DEPTH];
   logic [VALUE_W-1:0]     right_value [DEPTH];
   logic [DEPTH-1:0]       cell_match;
   logic [DEPTH-1:0]       hit;
   logic [IDX_W-1:0]       first_pos;
   logic [IDX_W-1:0]       tail_idx;
   logic [IDX_W-1:0]       rm_pos;
   logic                   found;
   logic                   cur_ok;

   assign req.ready = (phase_ff == ST_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign accept    = req.valid && req.ready;

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         if (g == DEPTH - 1) begin : g_last
            assign right_value[g] = '0;
         end else begin : g_mid
            assign right_value[g] = cell_value[g + 1];
         end
         olc_cell u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .idx         (IDX_W'(g)),
            .right_value (right_value[g]),
            .value       (cell_value[g]),
            .match       (cell_match[g])
         );
      end
   endgenerate

   // matches only count inside the stored part of the row
   always_comb begin
      hit       = '0;
      first_pos = '0;
      for (int i = 0; i < DEPTH; i++) begin
         hit[i] = cell_match[i] && (CNT_W'(i) < count_ff);
      end
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (hit[i]) begin
            first_pos = IDX_W'(i);
         end
      end
   end

   assign found    = |hit;
   assign tail_idx = IDX_W'(count_ff - CNT_W'(1));
   assign cur_ok   = present_ff && (CNT_W'(cur_ff) < count_ff);

   // cursor slot first, then head, then tail, then the first match in between
   always_comb begin
      if (cur_ok && hit[cur_ff]) begin
         rm_pos = cur_ff;
      end else if (hit[0]) begin
         rm_pos = '0;
      end else if (hit[tail_idx]) begin
         rm_pos = tail_idx;
      end else begin
         rm_pos = first_pos;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      cur_in     = cur_ff;
      present_in = present_ff;
      adv_in     = adv_ff;
      acc_in     = acc_ff;

      ctl.append_en = 1'b0;
      ctl.remove_en = 1'b0;
      ctl.key       = VALUE_W'(req.item_value);
      ctl.pos       = rm_pos;
      ctl.count     = count_ff;

      if (phase_ff == ST_RESP) begin
         phase_in = ST_IDLE;
      end else if (accept) begin
         phase_in = ST_RESP;
         acc_in   = 1'b0;
         case (req.cmd)
            CMD_APPEND: begin
               if (count_ff < CNT_W'(DEPTH)) begin
                  ctl.append_en = 1'b1;
                  acc_in        = 1'b1;
                  count_in      = count_ff + CNT_W'(1);
                  if (count_ff == '0) begin
                     cur_in     = '0;
                     present_in = 1'b1;
                  end
               end
            end
            CMD_REMOVE: begin
               if (found) begin
                  ctl.remove_en = 1'b1;
                  acc_in        = 1'b1;
                  count_in      = count_ff - CNT_W'(1);
                  if (rm_pos == '0) begin
                     cur_in = '0;
                     if (count_ff == CNT_W'(1)) begin
                        present_in = 1'b0;
                     end else begin
                        present_in = 1'b1;
                        adv_in     = 1'b0;
                     end
                  end else begin
                     cur_in     = rm_pos - IDX_W'(1);
                     present_in = 1'b1;
                  end
               end
            end
            CMD_ADVANCE: begin
               if (present_ff) begin
                  if (adv_ff) begin
                     if ((CNT_W'(cur_ff) + CNT_W'(1)) >= count_ff) begin
                        present_in = 1'b0;
                        cur_in     = '0;
                     end else begin
                        cur_in = cur_ff + IDX_W'(1);
                     end
                  end else begin
                     adv_in = 1'b1;
                  end
               end
            end
            CMD_RESTART: begin
               cur_in     = '0;
               present_in = (count_ff != '0);
               adv_in     = 1'b1;
            end
            CMD_CLEAR: begin
               count_in   = '0;
               cur_in     = '0;
               present_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (phase_ff == ST_RESP) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= ST_IDLE;
         count_ff     <= '0;
         cur_ff       <= '0;
         present_ff   <= 1'b0;
         adv_ff       <= 1'b1;
         acc_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         cur_ff       <= cur_in;
         present_ff   <= present_in;
         adv_ff       <= adv_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload is read from the row after it has settled
   always_ff @(posedge clock) begin
      if (phase_ff == ST_RESP) begin
         rsp_acc_ff   <= acc_ff;
         rsp_count_ff <= ENTRY_CNT_W'(count_ff);
         rsp_cv_ff    <= cur_ok;
         rsp_value_ff <= cur_ok ? ITEM_W'(cell_value[cur_ff]) : '0;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.accepted     = rsp_acc_ff;
   assign rsp.entry_count  = rsp_count_ff;
   assign rsp.cursor_valid = rsp_cv_ff;
   assign rsp.cursor_value = rsp_value_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count beyond depth");

   a_cursor_in_list: assert property (@(posedge clock) disable iff (reset)
      present_ff |-> (CNT_W'(cur_ff) < count_ff))
      else $error("cursor present past the stored entries");

   a_accept_to_resp: assert property (@(posedge clock) disable iff (reset)
      accept |=> (phase_ff == ST_RESP) && !req.ready)
      else $error("accepted request did not enter the response cycle");

   a_full_append: assert property (@(posedge clock) disable iff (reset)
      (accept && req.cmd == CMD_APPEND && count_ff == CNT_W'(DEPTH))
         |=> $stable(count_ff) && !acc_ff)
      else $error("append to a full list changed the list");

endmodule

// File: design/olc_cell.sv
// list slot: loads the key on append or its right neighbor on remove, compares its value with the key
module olc_cell (
   input  logic                          clock,
   input  olc_pkg::olc_ctl_type          ctl,
   input  logic [olc_pkg::IDX_W-1:0]     idx,
   input  logic [olc_pkg::VALUE_W-1:0]   right_value,
   output logic [olc_pkg::VALUE_W-1:0]   value,
   output logic                          match
);
   import olc_pkg::*;

   logic [VALUE_W-1:0] value_ff, value_in;
   logic               shift_en;
   logic               load_en;

   // close the gap: every slot from the removed one up to the one before the old tail takes its neighbor
   assign shift_en = ctl.remove_en && (idx >= ctl.pos) &&
                     ((CNT_W'(idx) + CNT_W'(1)) < ctl.count);
   assign load_en  = ctl.append_en && (CNT_W'(idx) == ctl.count);

   always_comb begin
      value_in = value_ff;
      if (shift_en) begin
         value_in = right_value;
      end else if (load_en) begin
         value_in = ctl.key;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
   assign match = (value_ff == ctl.key);

endmodule

// File: sim/ordered_list_with_cursor_tb.sv
// ordered list with cursor testbench: directed and random traffic vs a list predictor
module ordered_list_with_cursor_tb;
   import olc_pkg::*;

   localparam int ITEM_TARGET    = 1350;
   localparam int PRESSURE_ITEMS = 24;
   localparam int PRESSURE_HOLD  = 150;
   localparam int IDLE_LIMIT     = 2000;
   localparam int POOL_N         = 6;
   localparam int PRINT_LIMIT    = 40;

   // codes the block must ignore
   localparam logic [CMD_W-1:0] CMD_RSVD_FIRST = 3'd5;
   localparam logic [CMD_W-1:0] CMD_RSVD_LAST  = 3'd7;

   typedef enum int {MODE_GROW, MODE_SHRINK, MODE_WALK, MODE_NOISE} traffic_mode_type;

   typedef struct packed {
      logic                   accepted;
      logic [ENTRY_CNT_W-1:0] entry_count;
      logic                   cursor_valid;
      logic [ITEM_W-1:0]      cursor_value;
   } list_rsp_type;

   logic clock;
   logic reset;

   olc_req_if req_bus ();
   olc_rsp_if rsp_bus ();

   ordered_list_with_cursor u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_bus.sink),
      .rsp   (rsp_bus.source)
   );

   // predicted list contents and cursor
   logic [VALUE_W-1:0] list_vals [DEPTH];
   int                 list_len;
   int                 cur_idx;
   logic               cur_on;
   logic               step_ok;

   list_rsp_type       expected_rsp_q [$];
   logic [ITEM_W-1:0]  value_pool [POOL_N];

   int   items_sent;
   int   rsp_seen;
   int   mismatch_count;
   int   idle_cycles;
   int   rsp_hold_req;
   logic tx_gaps_on;
   logic rx_gaps_on;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [ITEM_W-1:0] pick_value();
      if ($urandom_range(0, 99) < 70) return value_pool[$urandom_range(0, POOL_N - 1)];
      return $urandom();
   endfunction

   // mostly values that are stored, aimed at the cursor, head and tail
   function automatic logic [ITEM_W-1:0] pick_remove_value();
      int r;
      r = $urandom_range(0, 99);
      if (list_len == 0 || r < 10) return pick_value();
      if (r < 45 && cur_on && cur_idx < list_len) return list_vals[cur_idx];
      if (r < 60) return list_vals[0];
      if (r < 75) return list_vals[list_len - 1];
      return list_vals[$urandom_range(0, list_len - 1)];
   endfunction

   function automatic logic [CMD_W-1:0] pick_cmd(input traffic_mode_type mode);
      int               r;
      logic [CMD_W-1:0] any_cmd;
      r = $urandom_range(0, 99);
      any_cmd = CMD_W'($urandom());
      case (mode)
         MODE_GROW: begin
            if (r < 75) return CMD_APPEND;
            if (r < 87) return CMD_REMOVE;
            return CMD_ADVANCE;
         end
         MODE_SHRINK: begin
            if (r < 60) return CMD_REMOVE;
            if (r < 75) return CMD_APPEND;
            if (r < 90) return CMD_ADVANCE;
            if (r < 98) return CMD_RESTART;
            return CMD_CLEAR;
         end
         MODE_WALK: begin
            if (r < 55) return CMD_ADVANCE;
            if (r < 70) return CMD_RESTART;
            if (r < 92) return CMD_REMOVE;
            if (r < 98) return CMD_APPEND;
            return CMD_CLEAR;
         end
         default: return any_cmd;
      endcase
   endfunction

   function automatic void predict_list_response(input logic [CMD_W-1:0] c,
                                                 input logic [ITEM_W-1:0] v);
      list_rsp_type       r;
      logic               hit;
      int                 pos;
      int                 k;
      logic [VALUE_W-1:0] key;
      hit = 1'b0;
      key = v[VALUE_W-1:0];
      case (c)
         CMD_APPEND: begin
            if (list_len < DEPTH) begin
               list_vals[list_len] = key;
               if (list_len == 0) begin
                  cur_idx = 0;
                  cur_on  = 1'b1;
               end
               list_len++;
               hit = 1'b1;
            end
         end
         CMD_REMOVE: begin
            pos = -1;
            // cursor entry first, then head, tail, first match in between
            if (list_len > 0) begin
               if (cur_on && cur_idx < list_len && list_vals[cur_idx] == key)
                  pos = cur_idx;
               else if (list_vals[0] == key)
                  pos = 0;
               else if (list_vals[list_len - 1] == key)
                  pos = list_len - 1;
               else
                  for (k = 1; k + 1 < list_len; k++)
                     if (pos < 0 && list_vals[k] == key) pos = k;
            end
            if (pos >= 0) begin
               hit = 1'b1;
               for (k = pos; k + 1 < list_len; k++) list_vals[k] = list_vals[k + 1];
               list_len--;
               if (pos == 0) begin
                  cur_idx = 0;
                  cur_on  = (list_len > 0);
                  if (list_len > 0) step_ok = 1'b0;
               end else begin
                  cur_idx = pos - 1;
                  cur_on  = 1'b1;
               end
            end
         end
         CMD_ADVANCE: begin
            if (cur_on) begin
               if (step_ok) begin
                  cur_idx++;
                  if (cur_idx >= list_len) begin
                     cur_on  = 1'b0;
                     cur_idx = 0;
                  end
               end else begin
                  step_ok = 1'b1;
               end
            end
         end
         CMD_RESTART: begin
            cur_idx = 0;
            cur_on  = (list_len > 0);
            step_ok = 1'b1;
         end
         CMD_CLEAR: begin
            list_len = 0;
            cur_idx  = 0;
            cur_on   = 1'b0;
         end
         default: ;
      endcase
      r.accepted    = hit;
      r.entry_count = ENTRY_CNT_W'(list_len);
      if (cur_on && cur_idx < list_len) begin
         r.cursor_valid = 1'b1;
         r.cursor_value = list_vals[cur_idx];
      end else begin
         r.cursor_valid = 1'b0;
         r.cursor_value = '0;
      end
      expected_rsp_q.push_back(r);
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < PRINT_LIMIT)
         $display("mismatch in response %0d, %s: got %0h expected %0h",
                  rsp_seen, what, got, want);
      mismatch_count++;
   endtask

   // called at a falling edge, returns at the falling edge after the accept
   task automatic send_request(input logic [CMD_W-1:0] c, input logic [ITEM_W-1:0] v);
      int gap;
      gap = tx_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.cmd        <= c;
      req_bus.item_value <= v;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_list_response(c, v);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic test_directed_cases();
      logic [CMD_W-1:0] c;
      tx_gaps_on = 1'b0;
      rx_gaps_on = 1'b0;
      // empty list corner cases
      send_request(CMD_REMOVE, 32'h0000_0000);
      send_request(CMD_ADVANCE, 32'h0);
      send_request(CMD_RESTART, 32'h0);
      send_request(CMD_APPEND, 32'hFFFF_FFFF);
      send_request(CMD_APPEND, 32'h0000_0000);
      send_request(CMD_APPEND, 32'hA5A5_A5A5);
      send_request(CMD_APPEND, 32'h5A5A_5A5A);
      send_request(CMD_APPEND, 32'h1234_5678);
      send_request(CMD_ADVANCE, 32'h0);
      send_request(CMD_ADVANCE, 32'h0);
      // entry under the cursor, then the head with its one-advance hold
      send_request(CMD_REMOVE, 32'hA5A5_A5A5);
      send_request(CMD_REMOVE, 32'hFFFF_FFFF);
      send_request(CMD_ADVANCE, 32'h0);
      send_request(CMD_ADVANCE, 32'h0);
      send_request(CMD_REMOVE, 32'h1234_5678);
      send_request(CMD_APPEND, 32'h0000_0000);
      send_request(CMD_APPEND, 32'h0000_0077);
      send_request(CMD_RESTART, 32'h0);
      send_request(CMD_REMOVE, 32'h5A5A_5A5A);
      send_request(CMD_REMOVE, 32'hDEAD_BEEF);
      // walk off the tail, then remove with no cursor
      repeat (3) send_request(CMD_ADVANCE, 32'h0);
      send_request(CMD_REMOVE, 32'h0000_0000);
      send_request(CMD_CLEAR, 32'h0);
      for (c = CMD_RSVD_FIRST; c != CMD_RSVD_LAST; c++) send_request(c, 32'hFFFF_FFFF);
      send_request(CMD_RSVD_LAST, 32'h0);
   endtask

   task automatic test_random_traffic();
      traffic_mode_type  mode;
      int                burst;
      logic [CMD_W-1:0]  c;
      logic [ITEM_W-1:0] v;
      while (items_sent < ITEM_TARGET - PRESSURE_ITEMS) begin
         mode       = traffic_mode_type'($urandom_range(MODE_GROW, MODE_NOISE));
         burst      = $urandom_range(4, 40);
         tx_gaps_on = ($urandom_range(0, 3) != 0);
         rx_gaps_on = ($urandom_range(0, 3) != 0);
         repeat (burst) begin
            c = pick_cmd(mode);
            v = (c == CMD_REMOVE) ? pick_remove_value() : pick_value();
            send_request(c, v);
         end
      end
   endtask

   // receiver holds off while requests keep coming, so the block stalls its input
   task automatic test_output_backpressure();
      logic [CMD_W-1:0] c;
      tx_gaps_on   = 1'b0;
      rx_gaps_on   = 1'b1;
      rsp_hold_req = PRESSURE_HOLD;
      repeat (PRESSURE_ITEMS) begin
         c = pick_cmd(MODE_GROW);
         send_request(c, (c == CMD_REMOVE) ? pick_remove_value() : pick_value());
      end
   endtask

   // response side: random ready gaps plus the long hold-off
   initial begin : rsp_ready_drive
      int stall_left;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_req > 0) begin
            stall_left   = rsp_hold_req;
            rsp_hold_req = 0;
         end
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (rx_gaps_on) stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      list_rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_rsp_q.size() == 0) begin
            report_mismatch("response with no request outstanding",
                            32'(rsp_bus.entry_count), 32'd0);
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_bus.accepted !== want.accepted)
               report_mismatch("accepted", 32'(rsp_bus.accepted), 32'(want.accepted));
            if (rsp_bus.entry_count !== want.entry_count)
               report_mismatch("entry_count", 32'(rsp_bus.entry_count),
                               32'(want.entry_count));
            if (rsp_bus.cursor_valid !== want.cursor_valid)
               report_mismatch("cursor_valid", 32'(rsp_bus.cursor_valid),
                               32'(want.cursor_valid));
            if (rsp_bus.cursor_value !== want.cursor_value)
               report_mismatch("cursor_value", 32'(rsp_bus.cursor_value),
                               32'(want.cursor_value));
         end
         rsp_seen++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d cycles with no handshake", idle_cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      int k;
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.cmd        <= CMD_APPEND;
      req_bus.item_value <= '0;
      idle_cycles        = 0;
      items_sent         = 0;
      rsp_seen           = 0;
      mismatch_count     = 0;
      rsp_hold_req       = 0;
      tx_gaps_on         = 1'b0;
      rx_gaps_on         = 1'b0;
      list_len           = 0;
      cur_idx            = 0;
      cur_on             = 1'b0;
      step_ok            = 1'b1;
      value_pool[0]      = 32'h0000_0000;
      value_pool[1]      = 32'hFFFF_FFFF;
      for (k = 2; k < POOL_N; k++) value_pool[k] = $urandom();

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_random_traffic();
      test_output_backpressure();
      req_bus.valid <= 1'b0;

      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// File: filelist.f
design/olc_pkg.sv
design/olc_if.sv
design/olc_cell.sv
design/ordered_list_with_cursor.sv
sim/ordered_list_with_cursor_tb.sv
